/* design/ubx_fp_pkg.sv */
// ----------------------------------------------------------------------------
// ubx_fp_pkg
// shared types and constants of the ubx frame parser
// ----------------------------------------------------------------------------
package ubx_fp_pkg;

  // sync pair
  localparam logic [7:0] SYNC_ONE = 8'hB5;
  localparam logic [7:0] SYNC_TWO = 8'h62;

  // register reset values (class 0x01, id 0x07)
  localparam logic [7:0] WATCH_CLASS_RST = 8'h01;
  localparam logic [7:0] WATCH_ID_RST    = 8'h07;

  // register indexes
  localparam logic CFG_WATCH_CLASS = 1'b0;
  localparam logic CFG_WATCH_ID    = 1'b1;

  // parser phases
  localparam logic [3:0] PH_SYNC1   = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LEN_LO  = 4'd4;
  localparam logic [3:0] PH_LEN_HI  = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CK_A    = 4'd7;
  localparam logic [3:0] PH_CK_B    = 4'd8;

  // frame status codes
  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_WATCHED  = 3'd1;
  localparam logic [2:0] ST_OTHER    = 3'd2;
  localparam logic [2:0] ST_CKA_FAIL = 3'd3;
  localparam logic [2:0] ST_CKB_FAIL = 3'd4;
  localparam logic [2:0] ST_TOO_LONG = 3'd5;

  typedef struct packed {
    logic [7:0] watch_class;
    logic [7:0] watch_id;
  } cfg_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [8:0]  payload_offset;
    logic [2:0]  frame_status;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] msg_length;
  } result_t;

endpackage

/* design/ubx_frame_parser.sv */
// ----------------------------------------------------------------------------
// ubx_frame_parser
// ubx binary frame parser with 8-bit fletcher checksum
// ----------------------------------------------------------------------------
// Takes one received byte per item and returns exactly one result item per
// byte. The parser hunts for the sync pair b5 62, captures class, id and the
// little-endian 16-bit length, runs the fletcher sums a and b over class, id,
// length and payload, and checks the two trailing bytes. Payload bytes come
// out with their offset (modulo 512); the last byte of a frame carries one
// status: watched accepted, other accepted, ck_a fail, ck_b fail, or too long
// (length above MAX_PAYLOAD, reported on the length high byte). After any
// status the parser resyncs. The watched class and id are registers 0 and 1
// of the write port (reset 0x01 and 0x07); write them only while idle. The
// consumer keeps its own payload snapshot and commits it on watched accepted.
// Rate: one item per cycle sustained while the result side keeps taking items.
// A byte is captured in an input register, and its frame step (one 8-bit add
// pair and the phase update) is then done into the result register, where
// the result waits until it is taken. Both stages stall only when the result
// register is full and not taken.
// ----------------------------------------------------------------------------
module ubx_frame_parser #(
  parameter int MAX_PAYLOAD = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  // received bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // payload_byte[7:0], payload_offset[16:8], frame_status[19:17],
  // msg_class[27:20], msg_id[35:28], msg_length[51:36], zero pad[55:52]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tuser    // payload_valid
);
  import ubx_fp_pkg::*;

  cfg_t    cfg_q;
  logic    s1_valid, s1_ready;
  logic [7:0] s1_byte;
  result_t res;

  // watched message registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.watch_class <= WATCH_CLASS_RST;
      cfg_q.watch_id    <= WATCH_ID_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_WATCH_CLASS: cfg_q.watch_class <= cfg_wdata_i;
        CFG_WATCH_ID:    cfg_q.watch_id    <= cfg_wdata_i;
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  // input register
  ubx_fp_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .out_valid_o (s1_valid),
    .out_ready_i (s1_ready),
    .out_byte_o  (s1_byte)
  );

  // frame step and result register
  ubx_fp_parse #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .in_byte_i   (s1_byte),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tuser = res.payload_valid;
  assign m_axis_tdata = {4'b0000, res.msg_length, res.msg_id, res.msg_class,
                         res.frame_status, res.payload_offset, res.payload_byte};

endmodule

/* design/ubx_fp_in_reg.sv */
// ----------------------------------------------------------------------------
// ubx_fp_in_reg
// input register stage for received bytes
// ----------------------------------------------------------------------------
module ubx_fp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

/* design/ubx_fp_parse.sv */
// ----------------------------------------------------------------------------
// ubx_fp_parse
// frame state, fletcher sums and result register
// ----------------------------------------------------------------------------
module ubx_fp_parse #(
  parameter int MAX_PAYLOAD = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ubx_fp_pkg::cfg_t  cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output ubx_fp_pkg::result_t res_o
);
  import ubx_fp_pkg::*;

  localparam int          CNT_W   = $clog2(MAX_PAYLOAD + 1);
  localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

  logic [3:0]       phase_q, phase_d;
  logic [7:0]       sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [7:0]       class_q, class_d, id_q, id_d;
  logic [15:0]      len_q, len_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W:0]   cnt_inc;
  logic [7:0]       acc_a, acc_b;
  logic             fire;
  logic             res_valid_q;
  result_t          res_q, res_d;

  assign in_ready_o  = !res_valid_q || res_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // running fletcher sums with this byte folded in
  assign acc_a   = sum_a_q + in_byte_i;
  assign acc_b   = sum_b_q + acc_a;
  assign cnt_inc = {1'b0, cnt_q} + {{CNT_W{1'b0}}, 1'b1};

  always_comb begin
    phase_d = phase_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    class_d = class_q;
    id_d    = id_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    res_d   = '0;
    unique case (phase_q)
      PH_SYNC2: begin
        if (in_byte_i == SYNC_TWO) begin
          sum_a_d = '0;
          sum_b_d = '0;
          phase_d = PH_CLASS;
        end else if (in_byte_i != SYNC_ONE) begin
          phase_d = PH_SYNC1;
        end
      end
      PH_CLASS: begin
        class_d = in_byte_i;
        sum_a_d = acc_a;
        sum_b_d = acc_b;
        phase_d = PH_ID;
      end
      PH_ID: begin
        id_d    = in_byte_i;
        sum_a_d = acc_a;
        sum_b_d = acc_b;
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_d   = {8'h00, in_byte_i};
        sum_a_d = acc_a;
        sum_b_d = acc_b;
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_d   = {in_byte_i, len_q[7:0]};
        sum_a_d = acc_a;
        sum_b_d = acc_b;
        cnt_d   = '0;
        if ({1'b0, len_d} > MAX_LEN) begin
          res_d.frame_status = ST_TOO_LONG;
          phase_d            = PH_SYNC1;
        end else if (len_d == 16'h0000) begin
          phase_d = PH_CK_A;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_a_d              = acc_a;
        sum_b_d              = acc_b;
        res_d.payload_valid  = 1'b1;
        res_d.payload_byte   = in_byte_i;
        res_d.payload_offset = 9'(cnt_q);
        cnt_d                = cnt_inc[CNT_W-1:0];
        if (17'(cnt_inc) >= {1'b0, len_q}) begin
          phase_d = PH_CK_A;
        end
      end
      PH_CK_A: begin
        if (in_byte_i == sum_a_q) begin
          phase_d = PH_CK_B;
        end else begin
          res_d.frame_status = ST_CKA_FAIL;
          phase_d            = PH_SYNC1;
        end
      end
      PH_CK_B: begin
        if (in_byte_i != sum_b_q) begin
          res_d.frame_status = ST_CKB_FAIL;
        end else if (class_q == cfg_i.watch_class && id_q == cfg_i.watch_id) begin
          res_d.frame_status = ST_WATCHED;
        end else begin
          res_d.frame_status = ST_OTHER;
        end
        phase_d = PH_SYNC1;
      end
      default: begin
        phase_d = (in_byte_i == SYNC_ONE) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
    res_d.msg_class  = class_d;
    res_d.msg_id     = id_d;
    res_d.msg_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC1;
      sum_a_q     <= '0;
      sum_b_q     <= '0;
      class_q     <= '0;
      id_q        <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d;
        sum_a_q <= sum_a_d;
        sum_b_q <= sum_b_d;
        class_q <= class_d;
        id_q    <= id_d;
        len_q   <= len_d;
        cnt_q   <= cnt_d;
      end
      if (in_ready_o) begin
        res_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  // payload bytes never carry a frame status
  a_payload_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.payload_valid |-> res_q.frame_status == ST_NONE)
    else $error("payload item carries a frame status");

  // every status ends the frame and restarts the sync hunt
  a_status_resync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_d.frame_status != ST_NONE |=> phase_q == PH_SYNC1)
    else $error("parser did not resync after a status");

  // the payload counter stays below the captured length
  a_count_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> 17'(cnt_q) < {1'b0, len_q})
    else $error("payload counter ran past frame length");

  // lengths beyond the buffer never reach the payload phase
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD || phase_q == PH_CK_A || phase_q == PH_CK_B
    |-> {1'b0, len_q} <= MAX_LEN)
    else $error("oversized frame entered payload");

  // a watched status names the watched message
  a_watched_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.frame_status == ST_WATCHED
    |-> res_q.msg_class == cfg_i.watch_class && res_q.msg_id == cfg_i.watch_id)
    else $error("watched status on another message");

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ubx frame parser
// ----------------------------------------------------------------------------
// Feeds received bytes on the slave stream, predicts each result item with an
// independent frame tracker (sync hunt, header capture, fletcher sums, status)
// and checks every result field in order. A short directed burst hits the
// sync, length and checksum corner cases. Three random phases then follow,
// each with its own watch registers and its own stall pattern.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ubx_fp_pkg::*;

  localparam int MAX_PAYLOAD = 512;
  localparam int STALL_LIMIT = 2000;  // cycles with no item moving on either side

  typedef enum logic [1:0] {CK_GOOD, CK_BAD_A, CK_BAD_B} ck_mode_e;

  // dut ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = CFG_WATCH_CLASS;
  logic [7:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // payload_byte, payload_offset, frame_status, msg_class, msg_id, msg_length
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;        // payload_valid

  // bytes waiting to go out; the front one is the item currently offered
  logic [7:0] rx_bytes_q[$];
  // predicted result items, oldest first
  result_t    parse_results_q[$];

  // stall percentages for the two sides
  int tx_idle = 19;
  int rx_idle = 58;

  // shadow of the watch registers
  logic [7:0] watched_class = WATCH_CLASS_RST;
  logic [7:0] watched_id    = WATCH_ID_RST;

  // frame tracker state
  logic [3:0]  trk_phase = PH_SYNC1;
  logic [7:0]  fl_a = '0;
  logic [7:0]  fl_b = '0;
  logic [7:0]  cur_class = '0;
  logic [7:0]  cur_id = '0;
  logic [15:0] cur_len = '0;
  logic [15:0] pay_count = '0;

  // bookkeeping
  int n_queued = 0;
  int n_bytes_in = 0;
  int n_checked = 0;
  int n_payload = 0;
  int n_bad = 0;
  int quiet_cycles = 0;
  int status_seen[6] = '{default: 0};

  ubx_frame_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // frame tracker: one call per accepted byte, returns the expected result
  // ---------------------------------------------------------------------------
  function automatic void fletcher_add(input logic [7:0] v);
    fl_a = fl_a + v;
    fl_b = fl_b + fl_a;
  endfunction

  function automatic result_t track_byte(input logic [7:0] c);
    result_t r;
    r = '0;
    r.frame_status = ST_NONE;
    case (trk_phase)
      PH_SYNC2: begin
        // a repeated b5 keeps waiting for 62, anything else restarts the hunt
        if (c == SYNC_TWO) begin
          fl_a = '0;
          fl_b = '0;
          trk_phase = PH_CLASS;
        end else if (c != SYNC_ONE) begin
          trk_phase = PH_SYNC1;
        end
      end
      PH_CLASS: begin
        cur_class = c;
        fletcher_add(c);
        trk_phase = PH_ID;
      end
      PH_ID: begin
        cur_id = c;
        fletcher_add(c);
        trk_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        cur_len = {8'h00, c};
        fletcher_add(c);
        trk_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        cur_len = {c, cur_len[7:0]};
        fletcher_add(c);
        pay_count = '0;
        if (cur_len > MAX_PAYLOAD) begin
          // oversize frame is flagged on the length high byte
          r.frame_status = ST_TOO_LONG;
          trk_phase = PH_SYNC1;
        end else if (cur_len == 16'd0) begin
          trk_phase = PH_CK_A;
        end else begin
          trk_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        fletcher_add(c);
        r.payload_valid  = 1'b1;
        r.payload_byte   = c;
        r.payload_offset = pay_count[8:0];
        pay_count = pay_count + 16'd1;
        if (pay_count >= cur_len) trk_phase = PH_CK_A;
      end
      PH_CK_A: begin
        if (c == fl_a) begin
          trk_phase = PH_CK_B;
        end else begin
          r.frame_status = ST_CKA_FAIL;
          trk_phase = PH_SYNC1;
        end
      end
      PH_CK_B: begin
        if (c != fl_b) r.frame_status = ST_CKB_FAIL;
        else if (cur_class == watched_class && cur_id == watched_id) r.frame_status = ST_WATCHED;
        else r.frame_status = ST_OTHER;
        trk_phase = PH_SYNC1;
      end
      default: begin
        trk_phase = (c == SYNC_ONE) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
    r.msg_class  = cur_class;
    r.msg_id     = cur_id;
    r.msg_length = cur_len;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers rx_bytes_q front, predicts on every accepted byte
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : rx_driver
    result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = track_byte(s_axis_tdata);
        parse_results_q.push_back(want);
        status_seen[want.frame_status]++;
        if (want.payload_valid) n_payload++;
        void'(rx_bytes_q.pop_front());
        n_bytes_in++;
      end
      // hold an item that is not taken yet, otherwise pick the next one or idle
      if (!s_axis_tvalid || s_axis_tready) begin
        if (rx_bytes_q.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= rx_bytes_q[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: unpacks each result item and checks it against the oldest one
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    result_t got;
    result_t want;
    logic    bad;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.payload_valid  = m_axis_tuser;
        got.payload_byte   = m_axis_tdata[7:0];
        got.payload_offset = m_axis_tdata[16:8];
        got.frame_status   = m_axis_tdata[19:17];
        got.msg_class      = m_axis_tdata[27:20];
        got.msg_id         = m_axis_tdata[35:28];
        got.msg_length     = m_axis_tdata[51:36];
        if (parse_results_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("[%0t] result with nothing expected: %p", $realtime, got);
        end else begin
          want = parse_results_q.pop_front();
          bad = (got.payload_valid != want.payload_valid) ||
                (got.payload_byte != want.payload_byte) ||
                (got.payload_offset != want.payload_offset) ||
                (got.frame_status != want.frame_status) ||
                (got.msg_class != want.msg_class) ||
                (got.msg_id != want.msg_id) ||
                (got.msg_length != want.msg_length);
          if (bad) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("[%0t] result %0d mismatch", $realtime, n_checked);
              $display("  expected vld=%0b byte=%02h off=%0d st=%0d cls=%02h id=%02h len=%0d",
                       want.payload_valid, want.payload_byte, want.payload_offset,
                       want.frame_status, want.msg_class, want.msg_id, want.msg_length);
              $display("  actual   vld=%0b byte=%02h off=%0d st=%0d cls=%02h id=%02h len=%0d",
                       got.payload_valid, got.payload_byte, got.payload_offset,
                       got.frame_status, got.msg_class, got.msg_id, got.msg_length);
            end
          end
          n_checked++;
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  // watchdog: any cycle where an item moves on either side clears the count
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] v);
    rx_bytes_q.push_back(v);
    n_queued++;
  endtask

  // byte that also enters the frame checksum
  task automatic push_summed(input logic [7:0] v, inout logic [7:0] a, inout logic [7:0] b);
    push_byte(v);
    a = a + v;
    b = b + a;
  endtask

  // sync, header, payload and checksum; oversize lengths stop after the header
  task automatic push_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input ck_mode_e mode);
    logic [7:0] a;
    logic [7:0] b;
    a = '0;
    b = '0;
    push_byte(SYNC_ONE);
    push_byte(SYNC_TWO);
    push_summed(cls, a, b);
    push_summed(id, a, b);
    push_summed(len[7:0], a, b);
    push_summed(len[15:8], a, b);
    if (len > MAX_PAYLOAD) return;
    for (int i = 0; i < len; i++) push_summed(8'($urandom_range(0, 255)), a, b);
    case (mode)
      CK_BAD_A: push_byte(a ^ 8'($urandom_range(1, 255)));
      CK_BAD_B: begin
        push_byte(a);
        push_byte(b ^ 8'($urandom_range(1, 255)));
      end
      default: begin
        push_byte(a);
        push_byte(b);
      end
    endcase
  endtask

  // junk between frames, biased toward the first sync byte
  task automatic push_noise();
    repeat ($urandom_range(1, 6))
      push_byte(($urandom_range(0, 3) == 0) ? SYNC_ONE : 8'($urandom_range(0, 255)));
  endtask

  // let the stream run dry and every predicted result arrive
  task automatic drain();
    do @(negedge clk_i); while (rx_bytes_q.size() != 0 || parse_results_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WATCH_CLASS) watched_class = val;
    else watched_id = val;
  endtask

  // mostly well-formed frames with random content, some broken ones and junk
  task automatic gen_traffic(input int target, input bit with_max);
    int         start;
    int         pick;
    logic [7:0] cls;
    logic [7:0] id;
    logic [15:0] len;
    @(negedge clk_i);
    start = n_queued;
    // one frame of the largest accepted size per call that asks for it
    if (with_max) push_frame(watched_class, watched_id, 16'(MAX_PAYLOAD), CK_GOOD);
    while (n_queued - start < target) begin
      pick = $urandom_range(0, 99);
      cls  = ($urandom_range(0, 9) < 4) ? watched_class : 8'($urandom_range(0, 255));
      id   = ($urandom_range(0, 9) < 5) ? watched_id : 8'($urandom_range(0, 255));
      case ($urandom_range(0, 19))
        0:       len = 16'($urandom_range(65, 200));
        1, 2, 3: len = 16'($urandom_range(9, 64));
        default: len = 16'($urandom_range(0, 8));
      endcase
      if (pick < 68) begin
        push_frame(cls, id, len, CK_GOOD);
      end else if (pick < 77) begin
        push_frame(cls, id, len, CK_BAD_A);
      end else if (pick < 86) begin
        push_frame(cls, id, len, CK_BAD_B);
      end else if (pick < 91) begin
        case ($urandom_range(0, 3))
          0:       len = 16'(MAX_PAYLOAD + 1);
          1:       len = 16'hFFFF;
          default: len = 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
        endcase
        push_frame(cls, id, len, CK_GOOD);
      end else if (pick < 96) begin
        push_noise();
      end else begin
        // frame cut short after a partial header
        push_byte(SYNC_ONE);
        push_byte(SYNC_TWO);
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0) push_noise();
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed burst with the reset watch registers (class 01, id 07)
    @(negedge clk_i);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(SYNC_ONE);
    push_byte(8'h00);                               // bad second sync byte
    push_byte(SYNC_ONE);                            // b5 b5 62: repeated first byte
    push_frame(8'h01, 8'h07, 16'd0, CK_GOOD);       // zero length, watched
    push_frame(8'hFF, 8'hFF, 16'hFFFF, CK_GOOD);    // oversize length
    push_frame(8'hFF, 8'h00, 16'd1, CK_BAD_A);      // ck_a fails, no ck_b awaited
    push_frame(8'h00, 8'hFF, 16'd2, CK_BAD_B);      // ck_b fails
    push_frame(8'h01, 8'h08, 16'd0, CK_GOOD);       // accepted, not watched
    drain();

    // sender idles lightly, receiver stalls a lot
    write_reg(CFG_WATCH_CLASS, 8'h00);
    write_reg(CFG_WATCH_ID, 8'hFF);
    gen_traffic(480, 1'b0);
    drain();

    // roles swapped, with a full drain half way through
    tx_idle = 58;
    rx_idle = 19;
    write_reg(CFG_WATCH_CLASS, 8'hFF);
    write_reg(CFG_WATCH_ID, 8'h00);
    gen_traffic(240, 1'b0);
    drain();
    gen_traffic(240, 1'b0);
    drain();

    // full rate on both sides, random watch pair, one maximum-size frame
    tx_idle = 0;
    rx_idle = 0;
    write_reg(CFG_WATCH_CLASS, 8'($urandom_range(1, 254)));
    write_reg(CFG_WATCH_ID, 8'($urandom_range(1, 254)));
    gen_traffic(500, 1'b1);
    drain();
    repeat (10) @(posedge clk_i);

    $display("covered %0d bytes, %0d results checked, %0d payload bytes, 4 watch settings",
             n_bytes_in, n_checked, n_payload);
    $display("statuses: watched %0d, other %0d, ck_a fail %0d, ck_b fail %0d, too long %0d",
             status_seen[ST_WATCHED], status_seen[ST_OTHER], status_seen[ST_CKA_FAIL],
             status_seen[ST_CKB_FAIL], status_seen[ST_TOO_LONG]);
    if (n_bad == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
